// ===== rtl/bbps_pkg.sv =====
// Shared types, codes and helpers for the buzzer beep pattern sequencer.
// No dependencies; imported by bbps_burst and the top level.
`timescale 1ns / 1ps

package bbps_pkg;

    localparam int unsigned PhaseW   = 17;
    localparam int unsigned TickW    = 10;
    localparam int unsigned MsW      = 16;
    localparam int unsigned DutyW    = 7;
    localparam int unsigned FreqW    = 15;
    localparam int unsigned LimitW   = 32;
    localparam int unsigned InDataW  = 40;   // mode + max_on_ms, padded to bytes
    localparam int unsigned OutDataW = 32;   // duty + freq + mode, padded to bytes

    typedef enum logic [2:0] {
        REQ_TICK     = 3'd0,
        REQ_SET_MODE = 3'd1,
        REQ_SET_MAX  = 3'd2,
        REQ_DISABLE  = 3'd3,
        REQ_ENABLE   = 3'd4,
        REQ_STOP     = 3'd5
    } t_req;

    typedef enum logic [2:0] {
        MODE_OFF    = 3'd0,
        MODE_BEEP1  = 3'd1,
        MODE_BEEP2  = 3'd2,
        MODE_BEEP3  = 3'd3,
        MODE_CONT   = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        CFG_SHORT_ON   = 3'd0,
        CFG_SHORT_OFF  = 3'd1,
        CFG_BURST_PER  = 3'd2,
        CFG_TICK_PER   = 3'd3,
        CFG_TONE_DUTY  = 3'd4,
        CFG_TONE_FREQ  = 3'd5
    } t_cfg_idx;

    // burst timing state
    typedef struct packed {
        logic [1:0]        target;
        logic [1:0]        beeps_done;
        logic [PhaseW-1:0] on_ph;
        logic [PhaseW-1:0] off_ph;
        logic [PhaseW-1:0] period;
        logic              tone;
        logic              tone_prev;
    } t_burst_st;

    // timing registers the burst step needs
    typedef struct packed {
        logic [TickW-1:0] tick_ms;
        logic [MsW-1:0]   short_on;
        logic [MsW-1:0]   short_off;
        logic [MsW-1:0]   burst_per;
        logic [DutyW-1:0] duty;
    } t_burst_cfg;

    // saturating 17-bit add of a tick period
    function automatic logic [PhaseW-1:0] add17(input logic [PhaseW-1:0] a,
                                                input logic [TickW-1:0] t);
        logic [PhaseW:0] s;
        s = {1'b0, a} + {{(PhaseW + 1 - TickW){1'b0}}, t};
        return s[PhaseW] ? {PhaseW{1'b1}} : s[PhaseW-1:0];
    endfunction

endpackage

// ===== rtl/bbps_burst.sv =====
// One tick of the short-beep burst timer: on/off phases, beep count, period restart.
// Depends on bbps_pkg.
`timescale 1ns / 1ps

module bbps_burst (
    input  bbps_pkg::t_burst_st        i_st,
    input  bbps_pkg::t_burst_cfg       i_cfg,
    output bbps_pkg::t_burst_st        o_st,
    output logic                       o_duty_wr,
    output logic [bbps_pkg::DutyW-1:0] o_duty_pct
);
    import bbps_pkg::*;

    logic [PhaseW-1:0] w_per;

    always_comb begin
        o_st       = i_st;
        o_duty_wr  = 1'b0;
        o_duty_pct = '0;
        w_per      = add17(i_st.period, i_cfg.tick_ms);

        if (i_st.beeps_done < i_st.target) begin
            if (i_st.tone) begin
                o_st.on_ph = add17(i_st.on_ph, i_cfg.tick_ms);
                if (o_st.on_ph >= {1'b0, i_cfg.short_on}) begin
                    o_st.tone   = 1'b0;
                    o_st.off_ph = '0;
                end
            end else begin
                o_st.off_ph = add17(i_st.off_ph, i_cfg.tick_ms);
                if (o_st.off_ph >= {1'b0, i_cfg.short_off}) begin
                    o_st.tone  = 1'b1;
                    o_st.on_ph = '0;
                end
            end
        end else begin
            o_st.tone = 1'b0;
        end

        // tone edge: issue duty, count beeps on rising edge
        if (i_st.tone_prev != o_st.tone) begin
            o_st.tone_prev = o_st.tone;
            o_duty_wr      = 1'b1;
            if (o_st.tone) begin
                o_duty_pct      = i_cfg.duty;
                o_st.beeps_done = i_st.beeps_done + 2'd1;
            end
        end

        o_st.period = w_per;
        if (w_per >= {1'b0, i_cfg.burst_per}) begin
            o_st.tone       = 1'b1;
            o_st.beeps_done = '0;
            o_st.on_ph      = '0;
            o_st.off_ph     = '0;
            o_st.period     = '0;
        end
    end

endmodule

// ===== rtl/buzzer_beep_pattern_sequencer.sv =====
// Buzzer beep pattern sequencer: top level with command decode and result register.
// Depends on bbps_pkg and bbps_burst.
// Registered result: an item accepted at an edge has its result valid after that edge.
// Throughput: 1 item per cycle unless a held result stalls; refilled in the cycle it drains.
// Reset (i_rst_n low, synchronous): configuration to defaults, buzzer enabled, mode off,
// all timers cleared and the result register emptied.
`timescale 1ns / 1ps

module buzzer_beep_pattern_sequencer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // config write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [2:0]                        i_cfg_index,
    input  logic [bbps_pkg::MsW-1:0]          i_cfg_data,
    // request items
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [bbps_pkg::InDataW-1:0]      i_s_tdata,  // [2:0] mode, [34:3] max_on_ms
    input  logic [2:0]                        i_s_tuser,  // [2:0] req_type
    // result items
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [bbps_pkg::OutDataW-1:0]     o_m_tdata,  // [6:0] duty_percent,
                                                          // [21:7] freq_hz, [24:22] mode_now
    output logic [1:0]                        o_m_tuser   // [0] duty_write, [1] freq_write
);
    import bbps_pkg::*;

    // configuration registers
    logic [MsW-1:0]   r_short_on, r_short_off, r_burst_per;
    logic [TickW-1:0] r_tick_ms;
    logic [DutyW-1:0] r_duty;
    logic [FreqW-1:0] r_freq;

    // sequencer state
    logic              r_enabled,   n_enabled;
    logic [2:0]        r_mode,      n_mode;
    logic [LimitW-1:0] r_limit,     n_limit;
    logic [LimitW-1:0] r_elapsed,   n_elapsed;
    t_burst_st         r_burst,     n_burst;

    // result register
    logic                r_out_valid;
    logic [OutDataW-1:0] r_out_data,  n_out_data;
    logic [1:0]          r_out_user,  n_out_user;

    // burst step
    t_burst_cfg        w_bcfg;
    t_burst_st         w_burst_nxt;
    logic              w_burst_dw;
    logic [DutyW-1:0]  w_burst_dp;

    // field unpack
    logic [2:0]        w_req;
    logic [2:0]        w_md;
    logic [LimitW-1:0] w_lim;

    // tick arithmetic
    logic              w_expired;
    logic [LimitW-1:0] w_el_base;
    logic [LimitW:0]   w_el_sum;
    logic [2:0]        w_mode_tick;

    // per-item result
    logic              w_dw, w_fw;
    logic [DutyW-1:0]  w_dp;
    logic [FreqW-1:0]  w_fh;

    logic              w_accept;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !r_out_valid || i_m_tready;
    assign w_accept    = i_s_tvalid && o_s_tready;

    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;
    assign o_m_tuser   = r_out_user;

    assign w_req = i_s_tuser;
    assign w_md  = i_s_tdata[2:0];
    assign w_lim = i_s_tdata[34:3];

    assign w_bcfg = '{tick_ms:   r_tick_ms,
                      short_on:  r_short_on,
                      short_off: r_short_off,
                      burst_per: r_burst_per,
                      duty:      r_duty};

    bbps_burst u_burst (
        .i_st       (r_burst),
        .i_cfg      (w_bcfg),
        .o_st       (w_burst_nxt),
        .o_duty_wr  (w_burst_dw),
        .o_duty_pct (w_burst_dp)
    );

    // max on-time check and saturating elapsed advance for a tick
    assign w_expired   = (r_limit != '0) && (r_elapsed >= r_limit);
    assign w_el_base   = w_expired ? r_limit : r_elapsed;
    assign w_el_sum    = {1'b0, w_el_base} + {{(LimitW + 1 - TickW){1'b0}}, r_tick_ms};
    assign w_mode_tick = w_expired ? MODE_OFF : r_mode;

    // command decode and next state
    always_comb begin
        n_enabled = r_enabled;
        n_mode    = r_mode;
        n_limit   = r_limit;
        n_elapsed = r_elapsed;
        n_burst   = r_burst;
        w_dw      = 1'b0;
        w_dp      = '0;
        w_fw      = 1'b0;
        w_fh      = '0;

        unique case (t_req'(w_req))
            REQ_TICK: begin
                if (r_enabled) begin
                    if (r_limit != '0) begin
                        if (w_expired) begin
                            n_mode  = MODE_OFF;
                            n_limit = '0;
                            w_dw    = 1'b1;
                        end
                        n_elapsed = w_el_sum[LimitW] ? {LimitW{1'b1}} : w_el_sum[LimitW-1:0];
                    end
                    if (w_mode_tick >= MODE_BEEP1 && w_mode_tick <= MODE_BEEP3) begin
                        n_burst = w_burst_nxt;
                        if (w_burst_dw) begin
                            w_dw = 1'b1;
                            w_dp = w_burst_dp;
                        end
                    end
                end
            end
            REQ_SET_MODE: begin
                if (w_md <= MODE_CONT) begin
                    n_mode = w_md;
                    if (w_md == MODE_OFF) begin
                        n_elapsed = r_limit;
                        w_dw      = 1'b1;
                    end else begin
                        n_burst.beeps_done = '0;
                        n_burst.on_ph      = '0;
                        n_burst.off_ph     = '0;
                        n_burst.period     = '0;
                        if (w_md == MODE_CONT) begin
                            n_burst.target = '0;
                            w_dw           = 1'b1;
                            w_dp           = r_duty;
                        end else begin
                            n_burst.target = w_md[1:0];
                            n_elapsed      = '0;
                        end
                    end
                end
            end
            REQ_SET_MAX: begin
                n_limit   = w_lim;
                n_elapsed = '0;
            end
            REQ_DISABLE: begin
                w_fw      = 1'b1;
                w_dw      = 1'b1;
                n_enabled = 1'b0;
                n_mode    = MODE_OFF;
            end
            REQ_ENABLE: begin
                if (!r_enabled) begin
                    w_fw      = 1'b1;
                    w_fh      = r_freq;
                    w_dw      = 1'b1;
                    n_enabled = 1'b1;
                end
            end
            REQ_STOP: begin
                n_elapsed = r_limit;
                n_mode    = MODE_OFF;
                w_dw      = 1'b1;
            end
            default: ;  // unknown request: no effect
        endcase

        n_out_data = {{(OutDataW - 25){1'b0}}, n_mode, w_fh, w_dp};
        n_out_user = {w_fw, w_dw};
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_on  <= MsW'(100);
            r_short_off <= MsW'(100);
            r_burst_per <= MsW'(2000);
            r_tick_ms   <= TickW'(100);
            r_duty      <= DutyW'(50);
            r_freq      <= FreqW'(2700);
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SHORT_ON:  r_short_on  <= i_cfg_data;
                CFG_SHORT_OFF: r_short_off <= i_cfg_data;
                CFG_BURST_PER: r_burst_per <= i_cfg_data;
                CFG_TICK_PER:  r_tick_ms   <= i_cfg_data[TickW-1:0];
                CFG_TONE_DUTY: r_duty      <= i_cfg_data[DutyW-1:0];
                CFG_TONE_FREQ: r_freq      <= i_cfg_data[FreqW-1:0];
                default: ;  // index beyond the map: dropped
            endcase
        end
    end

    // state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled   <= 1'b1;
            r_mode      <= MODE_OFF;
            r_limit     <= '0;
            r_elapsed   <= '0;
            r_burst     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_enabled <= n_enabled;
                r_mode    <= n_mode;
                r_limit   <= n_limit;
                r_elapsed <= n_elapsed;
                r_burst   <= n_burst;
            end
            if (o_s_tready) begin
                r_out_valid <= i_s_tvalid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= n_out_data;
            r_out_user <= n_out_user;
        end
    end

endmodule
